[src/bffa_pkg.sv]
// Shared types and constants for the bitmap first-fit allocator.
// Used by every module of the block but bffa_ram; has no dependencies of its own.
package bffa_pkg;

    localparam int IDX_W            = 12;
    localparam int CNT_W            = 13;
    localparam int FUNC_W           = 2;
    localparam int WORD_W           = 64;
    localparam int WORD_SHIFT       = 6;
    localparam int COUNT_MAX        = 8191;
    localparam int INODE_SCAN_START = 1;
    localparam int ADDR_W           = 4;
    localparam int DATA_W           = 32;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd3;

    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_DATA  = 1'b1;

    localparam logic [1:0] REG_DATA_FIRST  = 2'd0;
    localparam logic [1:0] REG_INODE_START = 2'd1;
    localparam logic [1:0] REG_DATA_START  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic eval;
        logic out_load;
        logic clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic is_alloc;
        logic hit;
        logic last_word;
        logic clear_last;
    } sts_t;

    // Free counter load requests from the register file.
    typedef struct packed {
        logic             inode_load;
        logic             data_load;
        logic [CNT_W-1:0] value;
    } cnt_load_t;

endpackage

[src/bffa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module bffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bffa_regs.sv]
// APB-style configuration registers of the allocator.
// Depends on bffa_pkg for register codes and the counter load struct.
module bffa_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bffa_pkg::ADDR_W-1:0]    paddr,
    input  logic [bffa_pkg::DATA_W-1:0]    pwdata,
    output logic [bffa_pkg::DATA_W-1:0]    prdata,
    output logic [bffa_pkg::IDX_W-1:0]     data_first_block,
    output bffa_pkg::cnt_load_t            cnt_load
);

    logic [bffa_pkg::IDX_W-1:0] data_first_reg;
    logic [bffa_pkg::CNT_W-1:0] inode_start_reg;
    logic [bffa_pkg::CNT_W-1:0] data_start_reg;
    logic [1:0]                 reg_idx;
    logic                       wr_en;

    assign reg_idx = paddr[bffa_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_first_reg  <= '0;
            inode_start_reg <= '0;
            data_start_reg  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                bffa_pkg::REG_DATA_FIRST:  data_first_reg  <= pwdata[bffa_pkg::IDX_W-1:0];
                bffa_pkg::REG_INODE_START: inode_start_reg <= pwdata[bffa_pkg::CNT_W-1:0];
                bffa_pkg::REG_DATA_START:  data_start_reg  <= pwdata[bffa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cnt_load.inode_load = wr_en && (reg_idx == bffa_pkg::REG_INODE_START);
        cnt_load.data_load  = wr_en && (reg_idx == bffa_pkg::REG_DATA_START);
        cnt_load.value      = pwdata[bffa_pkg::CNT_W-1:0];
    end

    always_comb begin
        unique case (reg_idx)
            bffa_pkg::REG_DATA_FIRST:  prdata = bffa_pkg::DATA_W'(data_first_reg);
            bffa_pkg::REG_INODE_START: prdata = bffa_pkg::DATA_W'(inode_start_reg);
            bffa_pkg::REG_DATA_START:  prdata = bffa_pkg::DATA_W'(data_start_reg);
            default:                   prdata = '0;
        endcase
    end

    assign data_first_block = data_first_reg;

endmodule

[src/bffa_ctrl.sv]
// Controller state machine of the allocator: sequences clear, read, scan and
// result hand-off. Depends on bffa_pkg for the command and status structs.
module bffa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output bffa_pkg::cmd_t   cmd,
    input  bffa_pkg::sts_t   sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = sts.skip ? ST_DONE : ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                // A scan keeps walking words until a clear bit or the last word.
                if (!sts.is_alloc || sts.hit || sts.last_word) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[src/bffa_dp.sv]
// Datapath of the allocator: the two used-bit maps, the word scanner with its
// priority encoder, the free counters and the result registers.
// Depends on bffa_pkg and bffa_ram.
module bffa_dp #(
    parameter int POOL_BITS = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bffa_pkg::cmd_t                cmd,
    output bffa_pkg::sts_t                sts,
    input  logic [bffa_pkg::FUNC_W-1:0]   s_func,
    input  logic                          s_pool,
    input  logic [bffa_pkg::IDX_W-1:0]    s_index,
    input  logic                          s_write_value,
    input  logic [bffa_pkg::IDX_W-1:0]    data_first_block,
    input  bffa_pkg::cnt_load_t           cnt_load,
    output logic [bffa_pkg::IDX_W-1:0]    m_granted_index,
    output logic                          m_no_space,
    output logic                          m_bit_value,
    output logic [bffa_pkg::CNT_W-1:0]    m_free_count
);

    localparam int WORD_W = bffa_pkg::WORD_W;
    localparam int POS_W  = bffa_pkg::WORD_SHIFT;
    localparam int IDX_W  = bffa_pkg::IDX_W;
    localparam int CNT_W  = bffa_pkg::CNT_W;
    localparam int WORDS  = POOL_BITS / WORD_W;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W  = $clog2(POOL_BITS);
    localparam int EXT_W  = ((BIT_W > IDX_W) ? BIT_W : IDX_W) + 1;
    localparam logic [EXT_W-1:0] POOL_LIM = EXT_W'(POOL_BITS);
    localparam int CAP_INT = (POOL_BITS < bffa_pkg::COUNT_MAX) ? POOL_BITS
                                                               : bffa_pkg::COUNT_MAX;
    localparam logic [CNT_W-1:0] CAP       = CNT_W'(CAP_INT);
    localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);

    logic [bffa_pkg::FUNC_W-1:0] func_reg;
    logic                        pool_reg;
    logic [POS_W-1:0]            lo_reg;
    logic [AW-1:0]               word_reg;
    logic                        wval_reg;
    logic                        skip_reg;
    logic                        first_reg;
    logic [AW-1:0]               clr_addr_reg;
    logic [CNT_W-1:0]            inode_cnt_reg;
    logic [CNT_W-1:0]            data_cnt_reg;
    logic [IDX_W-1:0]            res_granted_reg;
    logic                        res_nospace_reg;
    logic                        res_bitv_reg;
    logic [IDX_W-1:0]            m_granted_reg;
    logic                        m_nospace_reg;
    logic                        m_bitv_reg;
    logic [CNT_W-1:0]            m_count_reg;

    logic [EXT_W-1:0]  tgt_ext;
    logic [WORD_W-1:0] inode_rdata;
    logic [WORD_W-1:0] data_rdata;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] lo_bit;
    logic [WORD_W-1:0] scan_word;
    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] grant_bit;
    logic [WORD_W-1:0] new_word;
    logic [POS_W-1:0]  pos;
    logic              hit;
    logic              is_alloc;
    logic              last_word;
    logic              wr_en;
    logic              rd_en;
    logic              advance;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [WORD_W-1:0] wdata;
    logic [CNT_W-1:0]  sel_cnt;
    logic [CNT_W-1:0]  cnt_upd;
    logic              cnt_we;
    logic [CNT_W-1:0]  ld_val;

    // Allocation starts at the pool's first eligible bit; other functions
    // address the requested bit.
    always_comb begin
        if (s_func == bffa_pkg::FUNC_ALLOC) begin
            tgt_ext = (s_pool == bffa_pkg::POOL_INODE) ?
                      EXT_W'(bffa_pkg::INODE_SCAN_START) : EXT_W'(data_first_block);
        end else begin
            tgt_ext = EXT_W'(s_index);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= s_func;
            pool_reg  <= s_pool;
            lo_reg    <= tgt_ext[POS_W-1:0];
            word_reg  <= AW'(tgt_ext >> POS_W);
            wval_reg  <= s_write_value;
            skip_reg  <= (tgt_ext >= POOL_LIM);
            first_reg <= 1'b1;
        end else if (advance) begin
            word_reg  <= word_reg + AW'(1);
            first_reg <= 1'b0;
        end
    end

    assign is_alloc  = (func_reg == bffa_pkg::FUNC_ALLOC);
    assign last_word = (word_reg == LAST_WORD);
    assign rd_word   = (pool_reg == bffa_pkg::POOL_DATA) ? data_rdata : inode_rdata;
    assign lo_bit    = WORD_W'(1) << lo_reg;

    // Bits below the start position of the first word count as used.
    assign scan_word = first_reg ? (rd_word | (lo_bit - WORD_W'(1))) : rd_word;
    assign free_bits = ~scan_word;
    assign hit       = |free_bits;

    always_comb begin
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                pos = POS_W'(i);
            end
        end
    end

    assign grant_bit = WORD_W'(1) << pos;

    always_comb begin
        unique case (func_reg)
            bffa_pkg::FUNC_ALLOC: new_word = rd_word | grant_bit;
            bffa_pkg::FUNC_FREE:  new_word = rd_word & ~lo_bit;
            bffa_pkg::FUNC_WRITE: new_word = wval_reg ? (rd_word | lo_bit)
                                                      : (rd_word & ~lo_bit);
            default:              new_word = rd_word;
        endcase
    end

    assign wr_en   = cmd.eval && (func_reg != bffa_pkg::FUNC_READ) && (!is_alloc || hit);
    assign advance = cmd.eval && is_alloc && !hit && !last_word;
    assign rd_en   = (cmd.read && !skip_reg) || advance;
    assign raddr   = cmd.eval ? (word_reg + AW'(1)) : word_reg;
    assign waddr   = cmd.clear ? clr_addr_reg : word_reg;
    assign wdata   = cmd.clear ? '0 : new_word;

    bffa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_inode_map (
        .clk   (aclk),
        .we    (cmd.clear || (wr_en && (pool_reg == bffa_pkg::POOL_INODE))),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (inode_rdata)
    );

    bffa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_data_map (
        .clk   (aclk),
        .we    (cmd.clear || (wr_en && (pool_reg == bffa_pkg::POOL_DATA))),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (data_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Free counters: loads by configuration writes, which users keep to idle.
    assign sel_cnt = (pool_reg == bffa_pkg::POOL_DATA) ? data_cnt_reg : inode_cnt_reg;
    assign ld_val  = (cnt_load.value > CAP) ? CAP : cnt_load.value;
    assign cnt_we  = cmd.eval && ((is_alloc && hit) || (func_reg == bffa_pkg::FUNC_FREE));

    always_comb begin
        if (is_alloc) begin
            cnt_upd = (sel_cnt != '0) ? (sel_cnt - CNT_W'(1)) : sel_cnt;
        end else begin
            cnt_upd = (sel_cnt == CAP) ? CAP : (sel_cnt + CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inode_cnt_reg <= '0;
            data_cnt_reg  <= '0;
        end else begin
            if (cnt_load.inode_load) begin
                inode_cnt_reg <= ld_val;
            end else if (cnt_we && (pool_reg == bffa_pkg::POOL_INODE)) begin
                inode_cnt_reg <= cnt_upd;
            end
            if (cnt_load.data_load) begin
                data_cnt_reg <= ld_val;
            end else if (cnt_we && (pool_reg == bffa_pkg::POOL_DATA)) begin
                data_cnt_reg <= cnt_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read && skip_reg) begin
            res_granted_reg <= '0;
            res_nospace_reg <= is_alloc;
            res_bitv_reg    <= 1'b0;
        end else if (cmd.eval) begin
            res_granted_reg <= (is_alloc && hit) ? IDX_W'({word_reg, pos}) : '0;
            res_nospace_reg <= is_alloc && !hit && last_word;
            res_bitv_reg    <= (func_reg == bffa_pkg::FUNC_READ) ? rd_word[lo_reg] : 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_granted_reg <= res_granted_reg;
            m_nospace_reg <= res_nospace_reg;
            m_bitv_reg    <= res_bitv_reg;
            m_count_reg   <= sel_cnt;
        end
    end

    always_comb begin
        sts.skip       = skip_reg;
        sts.is_alloc   = is_alloc;
        sts.hit        = hit;
        sts.last_word  = last_word;
        sts.clear_last = (clr_addr_reg == LAST_WORD);
    end

    assign m_granted_index = m_granted_reg;
    assign m_no_space      = m_nospace_reg;
    assign m_bit_value     = m_bitv_reg;
    assign m_free_count    = m_count_reg;

endmodule

[src/bitmap_first_fit_allocator.sv]
// Top level of the bitmap first-fit allocator for an inode pool and a data pool.
// Depends on bffa_pkg, bffa_regs, bffa_ctrl and bffa_dp.
//
// Usage:
//   Requests enter on the s_ channel (func, pool, index, write_value) with a
//   valid/ready handshake; one result transaction per request leaves on the
//   m_ channel. The user must write configuration through the APB-style port
//   only while the block is idle, unchecked by the block; pready is always high.
//   Each map lives in a RAM of POOL_BITS/64 words of 64 bits.
//   From input to output valid, a free, read or write passes through the read,
//   evaluate and done states; an allocation that inspects n words (n is 1 to
//   POOL_BITS/64) stays in the evaluate state for each of them. The scan reads one
//   word per cycle from the map RAM and finds the lowest clear bit with a
//   64-bit priority encoder. An allocation that starts past the pool skips the
//   evaluate state and goes from the read state to done. A new request is taken in
//   the cycle after the previous result moves into the output register.
//   After reset a clearing pass writes zeros to both maps, one word per cycle,
//   over all POOL_BITS/64 words; s_ready stays low during it.
//   When the receiver stalls, the result waits in the output register; one
//   further request is processed and then waits until the register frees up.
module bitmap_first_fit_allocator #(
    parameter int POOL_BITS = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bffa_pkg::FUNC_W-1:0]   s_func,
    input  logic                          s_pool,
    input  logic [bffa_pkg::IDX_W-1:0]    s_index,
    input  logic                          s_write_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bffa_pkg::IDX_W-1:0]    m_granted_index,
    output logic                          m_no_space,
    output logic                          m_bit_value,
    output logic [bffa_pkg::CNT_W-1:0]    m_free_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bffa_pkg::ADDR_W-1:0]   paddr,
    input  logic [bffa_pkg::DATA_W-1:0]   pwdata,
    output logic [bffa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CAP_INT = (POOL_BITS < bffa_pkg::COUNT_MAX) ? POOL_BITS
                                                               : bffa_pkg::COUNT_MAX;

    bffa_pkg::cmd_t              cmd;
    bffa_pkg::sts_t              sts;
    bffa_pkg::cnt_load_t         cnt_load;
    logic [bffa_pkg::IDX_W-1:0]  data_first_block;

    assign pready = 1'b1;

    bffa_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .data_first_block (data_first_block),
        .cnt_load         (cnt_load)
    );

    bffa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bffa_dp #(
        .POOL_BITS (POOL_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_func           (s_func),
        .s_pool           (s_pool),
        .s_index          (s_index),
        .s_write_value    (s_write_value),
        .data_first_block (data_first_block),
        .cnt_load         (cnt_load),
        .m_granted_index  (m_granted_index),
        .m_no_space       (m_no_space),
        .m_bit_value      (m_bit_value),
        .m_free_count     (m_free_count)
    );

`ifndef SYNTHESIS
    // Only one request is in flight inside the controller.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while the previous one is still in flight");

    // A failed allocation grants nothing and reports no bit value.
    a_nospace_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_space) |-> (m_granted_index == '0) && !m_bit_value)
        else $error("no_space result carries a granted index or bit value");

    // Free counters never pass the pool cap.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_free_count <= bffa_pkg::CNT_W'(CAP_INT)))
        else $error("free count above the pool cap");
`endif

endmodule

[verif/tb_bitmap_first_fit_allocator.sv]
// Self-checking testbench for bitmap_first_fit_allocator: a directed table, then random traffic
// under three idle profiles, each result checked against its typed row or a built-in model of
// both pool maps. Depends on bffa_pkg and the RTL of the allocator only.
`timescale 1ns / 100ps

module tb_bitmap_first_fit_allocator;

    localparam int POOL_BITS  = 4096;
    localparam int COUNT_CAP  = (POOL_BITS < bffa_pkg::COUNT_MAX) ? POOL_BITS
                                                                  : bffa_pkg::COUNT_MAX;
    localparam int N_DIRECTED = 22;
    localparam int N_SEGMENTS = 6;
    localparam int SEG_ITEMS  = 308;

    typedef struct packed {
        logic [bffa_pkg::FUNC_W-1:0] func;
        logic                        pool;
        logic [bffa_pkg::IDX_W-1:0]  index;
        logic                        wval;
    } pool_request_t;

    typedef struct packed {
        logic [bffa_pkg::IDX_W-1:0] granted;
        logic                       no_space;
        logic                       bit_value;
        logic [bffa_pkg::CNT_W-1:0] free_count;
    } pool_reply_t;

    // One directed row; the reply fields are used only when typed is set.
    typedef struct packed {
        logic [bffa_pkg::FUNC_W-1:0] func;
        logic                        pool;
        logic [bffa_pkg::IDX_W-1:0]  index;
        logic                        wval;
        logic                        typed;
        logic [bffa_pkg::IDX_W-1:0]  granted;
        logic                        no_space;
        logic                        bit_value;
        logic [bffa_pkg::CNT_W-1:0]  free_count;
    } directed_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [bffa_pkg::FUNC_W-1:0]   s_func;
    logic                          s_pool;
    logic [bffa_pkg::IDX_W-1:0]    s_index;
    logic                          s_write_value;
    logic                          m_valid;
    logic                          m_ready;
    logic [bffa_pkg::IDX_W-1:0]    m_granted_index;
    logic                          m_no_space;
    logic                          m_bit_value;
    logic [bffa_pkg::CNT_W-1:0]    m_free_count;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bffa_pkg::ADDR_W-1:0]   paddr;
    logic [bffa_pkg::DATA_W-1:0]   pwdata;
    logic [bffa_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // Model state: used bits and free counters, indexed by pool.
    bit          used_map [2][POOL_BITS];
    int unsigned free_cnt [2];
    int unsigned first_block;

    pool_reply_t expected_replies [$];
    int          mismatches;
    int          snd_idle_pct;
    int          rcv_idle_pct;

    directed_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{bffa_pkg::FUNC_READ,  bffa_pkg::POOL_INODE, 12'd0, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_ALLOC, bffa_pkg::POOL_INODE, 12'd0, 1'b0, 1'b1, 12'd1, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_ALLOC, bffa_pkg::POOL_DATA,  12'd0, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_ALLOC, bffa_pkg::POOL_DATA,  12'hFFF, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_FREE,  bffa_pkg::POOL_INODE, 12'hFFF, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0, 13'd1},
        '{bffa_pkg::FUNC_WRITE, bffa_pkg::POOL_INODE, 12'd0, 1'b1, 1'b1, 12'd0, 1'b0, 1'b0, 13'd1},
        '{bffa_pkg::FUNC_READ,  bffa_pkg::POOL_INODE, 12'd0, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_ALLOC, bffa_pkg::POOL_INODE, 12'd0, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_WRITE, bffa_pkg::POOL_DATA,  12'hFFF, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_READ,  bffa_pkg::POOL_DATA,  12'hFFF, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_FREE,  bffa_pkg::POOL_DATA,  12'hFFF, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_READ,  bffa_pkg::POOL_DATA,  12'hFFF, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_WRITE, bffa_pkg::POOL_INODE, 12'd1, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_ALLOC, bffa_pkg::POOL_INODE, 12'd0, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_WRITE, bffa_pkg::POOL_INODE, 12'hAAA, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_READ,  bffa_pkg::POOL_INODE, 12'hAAA, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_WRITE, bffa_pkg::POOL_DATA,  12'h555, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_READ,  bffa_pkg::POOL_DATA,  12'h555, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_READ,  bffa_pkg::POOL_DATA,  12'h554, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_FREE,  bffa_pkg::POOL_INODE, 12'd0, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_READ,  bffa_pkg::POOL_INODE, 12'd0, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0},
        '{bffa_pkg::FUNC_WRITE, bffa_pkg::POOL_INODE, 12'hFFF, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 13'd0}
    };

    bitmap_first_fit_allocator #(
        .POOL_BITS(POOL_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_pool          (s_pool),
        .s_index         (s_index),
        .s_write_value   (s_write_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_index (m_granted_index),
        .m_no_space      (m_no_space),
        .m_bit_value     (m_bit_value),
        .m_free_count    (m_free_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Applies one request to the model maps and returns the reply it should produce.
    function automatic pool_reply_t apply_request(input pool_request_t r);
        pool_reply_t rsp;
        int unsigned b;
        int          p;
        bit          found;
        rsp   = '0;
        p     = (r.pool == bffa_pkg::POOL_DATA) ? 1 : 0;
        found = 1'b0;
        case (r.func)
            bffa_pkg::FUNC_ALLOC: begin
                b = (r.pool == bffa_pkg::POOL_DATA) ? first_block
                                                    : bffa_pkg::INODE_SCAN_START;
                while (b < POOL_BITS && !found) begin
                    if (!used_map[p][b])
                        found = 1'b1;
                    else
                        b++;
                end
                if (found) begin
                    used_map[p][b] = 1'b1;
                    // A grant with the counter already at zero leaves it at zero.
                    if (free_cnt[p] > 0)
                        free_cnt[p]--;
                    rsp.granted = bffa_pkg::IDX_W'(b);
                end else begin
                    rsp.no_space = 1'b1;
                end
            end
            bffa_pkg::FUNC_FREE: begin
                // The counter rises even when the bit was already clear.
                used_map[p][r.index] = 1'b0;
                if (free_cnt[p] < COUNT_CAP)
                    free_cnt[p]++;
            end
            bffa_pkg::FUNC_READ: begin
                rsp.bit_value = used_map[p][r.index];
            end
            default: begin
                used_map[p][r.index] = r.wval;
            end
        endcase
        rsp.free_count = bffa_pkg::CNT_W'(free_cnt[p]);
        return rsp;
    endfunction

    task automatic report_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Hands one request to the block; the model is updated at the accepting edge.
    task automatic issue_request(input pool_request_t r, input logic typed,
                                 input pool_reply_t typed_reply);
        pool_reply_t want;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_func        = r.func;
        s_pool        = r.pool;
        s_index       = r.index;
        s_write_value = r.wval;
        do @(posedge aclk); while (!s_ready);
        want = apply_request(r);
        expected_replies.push_back(typed ? typed_reply : want);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (expected_replies.size() != 0)
            @(negedge aclk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic write_register(input logic [1:0] reg_id, input int unsigned value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_id, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata !== bffa_pkg::DATA_W'(value))
            report_failure($sformatf("register %0d read back %0d, wrote %0d",
                                     reg_id, prdata, value));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_pools(input int unsigned first, input int unsigned inode_start,
                                 input int unsigned data_start);
        write_register(bffa_pkg::REG_DATA_FIRST, first);
        first_block = first;
        write_register(bffa_pkg::REG_INODE_START, inode_start);
        free_cnt[bffa_pkg::POOL_INODE] = (inode_start > COUNT_CAP) ? COUNT_CAP : inode_start;
        write_register(bffa_pkg::REG_DATA_START, data_start);
        free_cnt[bffa_pkg::POOL_DATA] = (data_start > COUNT_CAP) ? COUNT_CAP : data_start;
    endtask

    // Indexes cluster where allocations land so that scans run through populated words.
    function automatic pool_request_t random_request();
        pool_request_t r;
        int unsigned   roll;
        int unsigned   spot;
        roll = $urandom_range(99);
        if (roll < 35)
            r.func = bffa_pkg::FUNC_ALLOC;
        else if (roll < 55)
            r.func = bffa_pkg::FUNC_FREE;
        else if (roll < 75)
            r.func = bffa_pkg::FUNC_READ;
        else
            r.func = bffa_pkg::FUNC_WRITE;
        r.pool = 1'($urandom_range(1));
        r.wval = ($urandom_range(99) < 70);
        case ($urandom_range(3))
            0: spot = $urandom_range(POOL_BITS - 1);
            1: spot = $urandom_range(255);
            2: spot = first_block + $urandom_range(255);
            default: spot = POOL_BITS - 1 - $urandom_range(63);
        endcase
        if (spot > POOL_BITS - 1)
            spot = POOL_BITS - 1;
        r.index = bffa_pkg::IDX_W'(spot);
        return r;
    endfunction

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_replies
        pool_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                report_failure("result transaction with nothing outstanding");
            end else begin
                want = expected_replies.pop_front();
                if (m_granted_index !== want.granted || m_no_space !== want.no_space ||
                    m_bit_value !== want.bit_value || m_free_count !== want.free_count)
                    report_failure($sformatf(
                        "mismatch: exp %0d/%0b/%0b/%0d, got %0d/%0b/%0b/%0d",
                        want.granted, want.no_space, want.bit_value, want.free_count,
                        m_granted_index, m_no_space, m_bit_value, m_free_count));
            end
        end
    end

    initial begin : stimulus
        pool_request_t req;
        pool_reply_t   typed_reply;
        int unsigned   seg_first [N_SEGMENTS];
        int unsigned   seg_inode [N_SEGMENTS];
        int unsigned   seg_data  [N_SEGMENTS];
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = bffa_pkg::FUNC_ALLOC;
        s_pool        = bffa_pkg::POOL_INODE;
        s_index       = '0;
        s_write_value = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        snd_idle_pct  = 30;
        rcv_idle_pct  = 79;
        free_cnt[bffa_pkg::POOL_INODE] = 0;
        free_cnt[bffa_pkg::POOL_DATA]  = 0;
        first_block   = 0;

        // Counter starts at the cap, one below it, the full field, zero and random values.
        seg_first = '{0, 4095, $urandom_range(4095), 4032, $urandom_range(4095), 1};
        seg_inode = '{4096, 0, $urandom_range(8191), 1, $urandom_range(8191), 8191};
        seg_data  = '{4096, 8191, $urandom_range(8191), 4095, $urandom_range(8191), 0};

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows run against the reset configuration.
        for (int i = 0; i < N_DIRECTED; i++) begin
            req.func         = directed_rows[i].func;
            req.pool         = directed_rows[i].pool;
            req.index        = directed_rows[i].index;
            req.wval         = directed_rows[i].wval;
            typed_reply.granted    = directed_rows[i].granted;
            typed_reply.no_space   = directed_rows[i].no_space;
            typed_reply.bit_value  = directed_rows[i].bit_value;
            typed_reply.free_count = directed_rows[i].free_count;
            issue_request(req, directed_rows[i].typed, typed_reply);
        end

        for (int s = 0; s < N_SEGMENTS; s++) begin
            wait_drained();
            repeat (8) @(negedge aclk);
            program_pools(seg_first[s], seg_inode[s], seg_data[s]);
            if (s < 2) begin
                snd_idle_pct = 30;
                rcv_idle_pct = 79;
            end else if (s < 4) begin
                snd_idle_pct = 79;
                rcv_idle_pct = 30;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            for (int n = 0; n < SEG_ITEMS; n++) begin
                issue_request(random_request(), 1'b0, '0);
                if ($urandom_range(149) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (80) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
